/* hdl/stereo_comb_allpass_reverb_core_defines.svh */
// Assertion macros shared by the reverb core checker
`ifndef STEREO_COMB_ALLPASS_REVERB_CORE_DEFINES_SVH
`define STEREO_COMB_ALLPASS_REVERB_CORE_DEFINES_SVH

// Clocked assertion, quiet while reset is held
`define SCAR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scar checker: property failed");

// Clocked assertion that also runs through reset
`define SCAR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("scar checker: reset property failed");

`endif

/* hdl/scar_pkg.sv */
// Shared types, constants and helper functions for the stereo reverb core
package scar_pkg;

    localparam int BASE_RATE = 44100;
    localparam int SPREAD    = 23;
    localparam int SW        = 24;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 18;
    localparam int CIDX_W    = 4;
    localparam int AIDX_W    = 3;

    localparam int COMB_TUNE [8] = '{1, 72, 161, 240, 306, 375, 441, 501};
    localparam int AP_TUNE   [4] = '{556, 441, 341, 225};

    // register indexes on the configuration channel
    typedef enum logic [CFG_IW-1:0] {
        REG_INPUT_GAIN = 3'd0,
        REG_DAMPING    = 3'd1,
        REG_FEEDBACK   = 3'd2,
        REG_DRY_GAIN   = 3'd3,
        REG_WET_SAME   = 3'd4,
        REG_WET_CROSS  = 3'd5,
        REG_FREEZE     = 3'd6
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_GAIN, ST_XCALC,
        ST_C_RD, ST_C_MUL1, ST_C_MUL2, ST_C_LP, ST_C_MUL3, ST_C_WR,
        ST_A_INIT, ST_A_RD, ST_A_WR,
        ST_M_MUL, ST_M_ACC, ST_M_RND, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_CLEAR, OP_IDLE, OP_GAIN, OP_XCALC,
        OP_C_RD, OP_C_MUL1, OP_C_MUL2, OP_C_LP, OP_C_MUL3, OP_C_WR,
        OP_A_INIT, OP_A_RD, OP_A_WR,
        OP_M_MUL, OP_M_ACC, OP_M_RND, OP_OUT
    } t_op;

    // output mix terms
    typedef enum logic [1:0] {
        TERM_SAME, TERM_CROSS, TERM_DRY
    } t_term;

    typedef struct packed {
        logic [16:0] input_gain;
        logic [16:0] damping;
        logic [16:0] feedback;
        logic [17:0] dry_gain;
        logic [17:0] wet_same;
        logic [17:0] wet_cross;
        logic        freeze;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic              ch;
        logic [CIDX_W-1:0] cidx;
        logic [AIDX_W-1:0] aidx;
        t_term             term;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_accept;
        logic out_free;
    } t_status;

    // delay length in samples at a given rate, never below one
    function automatic int delay_len(int rate, int tune, int ch);
        int n;
        n = (rate * (tune + ((ch != 0) ? SPREAD : 0))) / BASE_RATE;
        return (n == 0) ? 1 : n;
    endfunction

    function automatic int comb_depth(int rate);
        return (rate * 4378) / BASE_RATE + 16;
    endfunction

    function automatic int ap_depth(int rate);
        return (rate * 3218) / BASE_RATE + 8;
    endfunction

    // round to nearest at bit 16, ties upward
    function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v + 48'sd32768;
        return t >>> 16;
    endfunction

    // clamp to the 24-bit sample range
    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* hdl/scar_if.sv */
// Handshake channel interfaces for samples, results and configuration
interface scar_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface scar_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_result;
    logic signed [23:0] right_result;
    modport source (output valid, left_result, right_result, input ready);
    modport sink   (input valid, left_result, right_result, output ready);
endinterface

interface scar_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [17:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/scar_regs.sv */
// Configuration register file of the reverb core
module scar_regs import scar_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scar_cfg_if.sink i_cfg,
    output t_cfg  o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, masked to each width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain <= 17'd983;
            r_cfg.damping    <= 17'd13107;
            r_cfg.feedback   <= 17'd55050;
            r_cfg.dry_gain   <= 18'd52429;
            r_cfg.wet_same   <= 18'd64881;
            r_cfg.wet_cross  <= 18'd0;
            r_cfg.freeze     <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_INPUT_GAIN: r_cfg.input_gain <= i_cfg.data[16:0];
                REG_DAMPING:    r_cfg.damping    <= i_cfg.data[16:0];
                REG_FEEDBACK:   r_cfg.feedback   <= i_cfg.data[16:0];
                REG_DRY_GAIN:   r_cfg.dry_gain   <= i_cfg.data;
                REG_WET_SAME:   r_cfg.wet_same   <= i_cfg.data;
                REG_WET_CROSS:  r_cfg.wet_cross  <= i_cfg.data;
                REG_FREEZE:     r_cfg.freeze     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/scar_ctrl.sv */
// Sequencer that walks the comb, allpass and mix steps of one item
module scar_ctrl import scar_pkg::*; #(
    parameter int NUM_COMBS     = 8,
    parameter int NUM_ALLPASSES = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int NC2 = 2 * NUM_COMBS;
    localparam int NA2 = 2 * NUM_ALLPASSES;
    localparam int CIW = $clog2(NC2);
    localparam int AIW = $clog2(NA2);

    t_state         r_state, n_state;
    logic           r_ch, n_ch;
    logic [CIW-1:0] r_cidx, n_cidx;
    logic [AIW-1:0] r_aidx, n_aidx;
    t_term          r_term, n_term;
    logic           w_comb_last, w_ap_last;

    // last filter of the current channel
    assign w_comb_last = r_cidx == (r_ch ? CIW'(NC2 - 1) : CIW'(NUM_COMBS - 1));
    assign w_ap_last   = r_aidx == (r_ch ? AIW'(NA2 - 1) : AIW'(NUM_ALLPASSES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ch    <= 1'b0;
            r_cidx  <= '0;
            r_aidx  <= '0;
            r_term  <= TERM_SAME;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cidx  <= n_cidx;
            r_aidx  <= n_aidx;
            r_term  <= n_term;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_status.in_accept) n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_XCALC;
            ST_XCALC:  n_state = ST_C_RD;
            ST_C_RD:   n_state = ST_C_MUL1;
            ST_C_MUL1: n_state = ST_C_MUL2;
            ST_C_MUL2: n_state = ST_C_LP;
            ST_C_LP:   n_state = ST_C_MUL3;
            ST_C_MUL3: n_state = ST_C_WR;
            ST_C_WR:   n_state = w_comb_last ? ST_A_INIT : ST_C_RD;
            ST_A_INIT: n_state = ST_A_RD;
            ST_A_RD:   n_state = ST_A_WR;
            ST_A_WR: begin
                if (w_ap_last) n_state = r_ch ? ST_M_MUL : ST_C_RD;
                else           n_state = ST_A_RD;
            end
            ST_M_MUL:  n_state = ST_M_ACC;
            ST_M_ACC:  n_state = (r_term == TERM_DRY) ? ST_M_RND : ST_M_MUL;
            ST_M_RND:  n_state = r_ch ? ST_OUT : ST_M_MUL;
            ST_OUT:    if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // stage counters
    always_comb begin
        n_ch   = r_ch;
        n_cidx = r_cidx;
        n_aidx = r_aidx;
        n_term = r_term;
        case (r_state)
            ST_XCALC: begin
                n_ch   = 1'b0;
                n_cidx = '0;
                n_aidx = '0;
            end
            ST_C_WR: n_cidx = CIW'(r_cidx + 1'b1);
            ST_A_WR: begin
                n_aidx = AIW'(r_aidx + 1'b1);
                if (w_ap_last) begin
                    n_ch   = ~r_ch;
                    n_term = TERM_SAME;
                end
            end
            ST_M_ACC: begin
                case (r_term)
                    TERM_SAME:  n_term = TERM_CROSS;
                    TERM_CROSS: n_term = TERM_DRY;
                    default:    n_term = TERM_SAME;
                endcase
            end
            ST_M_RND: begin
                n_ch   = ~r_ch;
                n_term = TERM_SAME;
            end
            default: ;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.ch   = r_ch;
        o_cmd.cidx = CIDX_W'(r_cidx);
        o_cmd.aidx = AIDX_W'(r_aidx);
        o_cmd.term = r_term;
        o_cmd.last = (r_state == ST_A_WR) && w_ap_last;
        case (r_state)
            ST_CLEAR:  o_cmd.op = OP_CLEAR;
            ST_IDLE:   o_cmd.op = OP_IDLE;
            ST_GAIN:   o_cmd.op = OP_GAIN;
            ST_XCALC:  o_cmd.op = OP_XCALC;
            ST_C_RD:   o_cmd.op = OP_C_RD;
            ST_C_MUL1: o_cmd.op = OP_C_MUL1;
            ST_C_MUL2: o_cmd.op = OP_C_MUL2;
            ST_C_LP:   o_cmd.op = OP_C_LP;
            ST_C_MUL3: o_cmd.op = OP_C_MUL3;
            ST_C_WR:   o_cmd.op = OP_C_WR;
            ST_A_INIT: o_cmd.op = OP_A_INIT;
            ST_A_RD:   o_cmd.op = OP_A_RD;
            ST_A_WR:   o_cmd.op = OP_A_WR;
            ST_M_MUL:  o_cmd.op = OP_M_MUL;
            ST_M_ACC:  o_cmd.op = OP_M_ACC;
            ST_M_RND:  o_cmd.op = OP_M_RND;
            ST_OUT:    o_cmd.op = OP_OUT;
            default:   o_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

/* hdl/scar_datapath.sv */
// Shared multiplier, delay memories and filter state of the reverb core
module scar_datapath import scar_pkg::*; #(
    parameter int SAMPLE_RATE   = 44100,
    parameter int NUM_COMBS     = 8,
    parameter int NUM_ALLPASSES = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_cmd    i_cmd,
    output t_status o_status,
    scar_in_if.sink    i_in,
    scar_out_if.source o_out
);

    localparam int NC2    = 2 * NUM_COMBS;
    localparam int NA2    = 2 * NUM_ALLPASSES;
    localparam int CIW    = $clog2(NC2);
    localparam int AIW    = $clog2(NA2);
    localparam int CDEPTH = comb_depth(SAMPLE_RATE);
    localparam int ADEPTH = ap_depth(SAMPLE_RATE);
    localparam int CAW    = $clog2(CDEPTH);
    localparam int AAW    = $clog2(ADEPTH);
    localparam int PW     = $clog2(delay_len(SAMPLE_RATE, AP_TUNE[0], 1) + 1);

    // start of each filter's segment in its memory
    function automatic int comb_base_f(int s);
        int b;
        b = 0;
        for (int k = 0; k < s; k++) begin
            b += delay_len(SAMPLE_RATE, COMB_TUNE[k % NUM_COMBS], k / NUM_COMBS);
        end
        return b;
    endfunction

    function automatic int ap_base_f(int s);
        int b;
        b = 0;
        for (int k = 0; k < s; k++) begin
            b += delay_len(SAMPLE_RATE, AP_TUNE[k % NUM_ALLPASSES], k / NUM_ALLPASSES);
        end
        return b;
    endfunction

    logic [CAW-1:0] w_cbase [NC2];
    logic [PW-1:0]  w_clen  [NC2];
    logic [AAW-1:0] w_abase [NA2];
    logic [PW-1:0]  w_alen  [NA2];

    for (genvar g = 0; g < NC2; g++) begin : g_comb_tab
        assign w_cbase[g] = CAW'(comb_base_f(g));
        assign w_clen[g]  = PW'(delay_len(SAMPLE_RATE, COMB_TUNE[g % NUM_COMBS],
                                          g / NUM_COMBS));
    end
    for (genvar g = 0; g < NA2; g++) begin : g_ap_tab
        assign w_abase[g] = AAW'(ap_base_f(g));
        assign w_alen[g]  = PW'(delay_len(SAMPLE_RATE, AP_TUNE[g % NUM_ALLPASSES],
                                          g / NUM_ALLPASSES));
    end

    // state and payload registers
    logic [CAW-1:0]     r_clr;
    logic signed [23:0] r_lp   [NC2];
    logic [PW-1:0]      r_cpos [NC2];
    logic [PW-1:0]      r_apos [NA2];
    logic               r_ovalid;
    logic signed [23:0] r_oleft, r_oright;
    logic signed [23:0] r_l, r_r, r_x, r_lpv, r_w;
    logic signed [23:0] r_wet_l, r_wet_r, r_res_l, r_res_r;
    logic signed [27:0] r_cacc;
    logic signed [43:0] r_prod;
    logic signed [45:0] r_macc;

    logic [23:0] r_cmem [CDEPTH];
    logic [23:0] r_amem [ADEPTH];
    logic [23:0] r_crdata, r_ardata;

    logic [CIW-1:0]     w_ci;
    logic [AIW-1:0]     w_ai;
    logic [CAW-1:0]     w_caddr, w_cwaddr;
    logic [AAW-1:0]     w_aaddr, w_awaddr;
    logic               w_cwe, w_awe;
    logic signed [23:0] w_cwdata, w_awdata, w_wnext;
    logic signed [23:0] w_crd, w_b, w_lpnew, w_mixres;
    logic [16:0]        w_g, w_d, w_fb;
    logic signed [18:0] w_omd;
    logic signed [24:0] w_ma;
    logic signed [18:0] w_mb;
    logic signed [43:0] w_prod;
    logic               w_accept, w_out_load;

    assign w_ci = i_cmd.cidx[CIW-1:0];
    assign w_ai = i_cmd.aidx[AIW-1:0];

    // freeze overrides the gains
    assign w_g   = i_cfg.freeze ? 17'd0 : i_cfg.input_gain;
    assign w_d   = i_cfg.freeze ? 17'd0 : i_cfg.damping;
    assign w_fb  = i_cfg.freeze ? 17'd65536 : i_cfg.feedback;
    assign w_omd = 19'sd65536 - signed'({2'b00, w_d});

    // handshakes
    assign i_in.ready         = (i_cmd.op == OP_IDLE);
    assign w_accept           = i_in.valid && i_in.ready;
    assign w_out_load         = (i_cmd.op == OP_OUT) && o_status.out_free;
    assign o_status.in_accept = w_accept;
    assign o_status.out_free  = !r_ovalid || o_out.ready;
    assign o_status.clr_done  = r_clr == CAW'(CDEPTH - 1);
    assign o_out.valid        = r_ovalid;
    assign o_out.left_result  = r_oleft;
    assign o_out.right_result = r_oright;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_GAIN: begin
                w_ma = 25'(r_l) + 25'(r_r);
                w_mb = signed'({2'b00, w_g});
            end
            OP_C_MUL1: begin
                w_ma = 25'(w_crd);
                w_mb = w_omd;
            end
            OP_C_MUL2: begin
                w_ma = 25'(r_lp[w_ci]);
                w_mb = signed'({2'b00, w_d});
            end
            OP_C_MUL3: begin
                w_ma = 25'(r_lpv);
                w_mb = signed'({2'b00, w_fb});
            end
            OP_M_MUL: begin
                case (i_cmd.term)
                    TERM_SAME: begin
                        w_ma = 25'(i_cmd.ch ? r_wet_r : r_wet_l);
                        w_mb = signed'({1'b0, i_cfg.wet_same});
                    end
                    TERM_CROSS: begin
                        w_ma = 25'(i_cmd.ch ? r_wet_l : r_wet_r);
                        w_mb = signed'({1'b0, i_cfg.wet_cross});
                    end
                    default: begin
                        w_ma = 25'(i_cmd.ch ? r_r : r_l);
                        w_mb = signed'({1'b0, i_cfg.dry_gain});
                    end
                endcase
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // comb and allpass arithmetic
    assign w_crd    = signed'(r_crdata);
    assign w_b      = signed'(r_ardata);
    assign w_lpnew  = sat24(rnd16(48'(r_macc) + 48'(r_prod)));
    assign w_cwdata = sat24(48'(r_x) + rnd16(48'(r_prod)));
    assign w_awdata = sat24(48'(r_w) + ((48'(w_b) + 48'sd1) >>> 1));
    assign w_wnext  = sat24(48'(w_b) - 48'(r_w));
    assign w_mixres = sat24(rnd16(48'(r_macc)));

    // memory addressing
    assign w_caddr  = w_cbase[w_ci] + CAW'(r_cpos[w_ci]);
    assign w_aaddr  = w_abase[w_ai] + AAW'(r_apos[w_ai]);
    assign w_cwe    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_C_WR);
    assign w_awe    = ((i_cmd.op == OP_CLEAR) && (r_clr < CAW'(ADEPTH)))
                   || (i_cmd.op == OP_A_WR);
    assign w_cwaddr = (i_cmd.op == OP_CLEAR) ? r_clr : w_caddr;
    assign w_awaddr = (i_cmd.op == OP_CLEAR) ? r_clr[AAW-1:0] : w_aaddr;

    // comb delay memory
    always_ff @(posedge i_clk) begin
        if (w_cwe) r_cmem[w_cwaddr] <= (i_cmd.op == OP_CLEAR) ? 24'd0 : w_cwdata;
        r_crdata <= r_cmem[w_caddr];
    end

    // allpass delay memory
    always_ff @(posedge i_clk) begin
        if (w_awe) r_amem[w_awaddr] <= (i_cmd.op == OP_CLEAR) ? 24'd0 : w_awdata;
        r_ardata <= r_amem[w_aaddr];
    end

    // control state, filter positions and lowpass stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NC2; k++) begin
                r_lp[k]   <= '0;
                r_cpos[k] <= '0;
            end
            for (int k = 0; k < NA2; k++) begin
                r_apos[k] <= '0;
            end
        end else begin
            if (i_cmd.op == OP_CLEAR) r_clr <= CAW'(r_clr + 1'b1);
            if (i_cmd.op == OP_C_LP) r_lp[w_ci] <= w_lpnew;
            if (i_cmd.op == OP_C_WR) begin
                r_cpos[w_ci] <= (PW'(r_cpos[w_ci] + 1'b1) == w_clen[w_ci])
                              ? '0 : PW'(r_cpos[w_ci] + 1'b1);
            end
            if (i_cmd.op == OP_A_WR) begin
                r_apos[w_ai] <= (PW'(r_apos[w_ai] + 1'b1) == w_alen[w_ai])
                              ? '0 : PW'(r_apos[w_ai] + 1'b1);
            end
            if (w_out_load)       r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_accept) begin
            r_l <= i_in.left_sample;
            r_r <= i_in.right_sample;
        end
        if (w_out_load) begin
            r_oleft  <= r_res_l;
            r_oright <= r_res_r;
        end
        case (i_cmd.op)
            OP_XCALC: begin
                r_x    <= sat24(rnd16(48'(r_prod)));
                r_cacc <= '0;
            end
            OP_C_MUL1: r_cacc <= r_cacc + 28'(w_crd);
            OP_C_MUL2: r_macc <= 46'(r_prod);
            OP_C_LP:   r_lpv  <= w_lpnew;
            OP_A_INIT: begin
                r_w    <= sat24(48'(r_cacc));
                r_cacc <= '0;
                r_macc <= '0;
            end
            OP_A_WR: begin
                r_w <= w_wnext;
                if (i_cmd.last) begin
                    if (i_cmd.ch) r_wet_r <= w_wnext;
                    else          r_wet_l <= w_wnext;
                end
            end
            OP_M_ACC: r_macc <= r_macc + 46'(r_prod);
            OP_M_RND: begin
                if (i_cmd.ch) r_res_r <= w_mixres;
                else          r_res_l <= w_mixres;
                r_macc <= '0;
            end
            default: ;
        endcase
    end

endmodule

/* hdl/stereo_comb_allpass_reverb_core.sv */
// Items are processed one at a time: input is ready only while the sequencer is idle,
//   so a new item is taken only after the last one has passed its output step. The pace is
//   set by one shared 25x19 multiplier and one port per delay memory, visited stage by stage.
// A result waiting at the output does not stop the next item from being accepted.
// Reset: synchronous; a clearing pass over comb_depth(SAMPLE_RATE) words (4394 at 44.1 kHz)
//   zeroes both delay memories with input not ready; configuration is taken throughout.
module stereo_comb_allpass_reverb_core import scar_pkg::*; #(
    parameter int SAMPLE_RATE   = 44100,
    parameter int NUM_COMBS     = 8,
    parameter int NUM_ALLPASSES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scar_in_if.sink    i_in,
    scar_out_if.source o_out,
    scar_cfg_if.sink   i_cfg
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    // configuration registers
    scar_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // step sequencer
    scar_ctrl #(
        .NUM_COMBS     (NUM_COMBS),
        .NUM_ALLPASSES (NUM_ALLPASSES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // filter datapath
    scar_datapath #(
        .SAMPLE_RATE   (SAMPLE_RATE),
        .NUM_COMBS     (NUM_COMBS),
        .NUM_ALLPASSES (NUM_ALLPASSES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

/* hdl/scar_checker.sv */
// Port-level checker for the reverb core and its bind
`include "stereo_comb_allpass_reverb_core_defines.svh"

module scar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_left,
    input logic [23:0] i_out_right
);

    // reset empties the output register
    `SCAR_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !i_out_valid)

    // one item at a time: busy right after an accept
    `SCAR_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready)

    // stalled result holds
    `SCAR_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)

    `SCAR_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_left) && $stable(i_out_right))

endmodule

bind stereo_comb_allpass_reverb_core scar_checker u_scar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.left_result),
    .i_out_right (o_out.right_result)
);

/* verif/scar_tb_pkg.sv */
`timescale 1ns / 1ps
// Testbench predictor of the stereo reverb and its expected-result store
package scar_tb_pkg;
    import scar_pkg::*;

    localparam int N_COMB = 8;
    localparam int N_AP   = 4;

    class reverb_scoreboard;
        // predictor state
        logic signed [23:0] comb_mem [];
        logic signed [23:0] ap_mem [];
        logic signed [23:0] comb_lp [2*N_COMB];
        int                 comb_pos [2*N_COMB];
        int                 ap_pos [2*N_AP];
        t_cfg               cfg;
        // pending output pairs
        logic signed [23:0] exp_left [$];
        logic signed [23:0] exp_right [$];
        int                 errors;
        int                 checked;

        function new();
            comb_mem = new[comb_depth(44100)];
            ap_mem = new[ap_depth(44100)];
            foreach (comb_mem[i]) comb_mem[i] = '0;
            foreach (ap_mem[i]) ap_mem[i] = '0;
            foreach (comb_lp[i]) comb_lp[i] = '0;
            foreach (comb_pos[i]) comb_pos[i] = 0;
            foreach (ap_pos[i]) ap_pos[i] = 0;
            cfg.input_gain = 17'd983;
            cfg.damping    = 17'd13107;
            cfg.feedback   = 17'd55050;
            cfg.dry_gain   = 18'd52429;
            cfg.wet_same   = 18'd64881;
            cfg.wet_cross  = 18'd0;
            cfg.freeze     = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [17:0] val);
            case (idx)
                REG_INPUT_GAIN: cfg.input_gain = val[16:0];
                REG_DAMPING:    cfg.damping    = val[16:0];
                REG_FEEDBACK:   cfg.feedback   = val[16:0];
                REG_DRY_GAIN:   cfg.dry_gain   = val;
                REG_WET_SAME:   cfg.wet_same   = val;
                REG_WET_CROSS:  cfg.wet_cross  = val;
                REG_FREEZE:     cfg.freeze     = val[0];
                default: ;
            endcase
        endfunction

        static function longint round16(longint v, int k);
            return (v + (longint'(1) <<< (k - 1))) >>> k;
        endfunction

        static function longint clamp24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        static function int taps(int tune, int ch);
            int n;
            n = (44100 * (tune + ((ch != 0) ? 23 : 0))) / 44100;
            return (n == 0) ? 1 : n;
        endfunction

        // run one stereo pair through the reverb and queue the output
        function void note_input(logic signed [23:0] l, logic signed [23:0] r);
            longint smp [2];
            longint wet [2];
            longint g, d, fb, x, acc, w, y, lp, b, v;
            int cbase, abase, s, n, p;
            g  = cfg.freeze ? 0 : longint'(cfg.input_gain);
            d  = cfg.freeze ? 0 : longint'(cfg.damping);
            fb = cfg.freeze ? 65536 : longint'(cfg.feedback);
            smp[0] = l;
            smp[1] = r;
            x = clamp24(round16((smp[0] + smp[1]) * g, 16));
            cbase = 0;
            abase = 0;
            for (int ch = 0; ch < 2; ch++) begin
                acc = 0;
                for (int j = 0; j < N_COMB; j++) begin
                    s = ch * N_COMB + j;
                    n = taps(COMB_TUNE[j], ch);
                    p = comb_pos[s];
                    if (p >= n) p = 0;
                    y = comb_mem[cbase + p];
                    lp = clamp24(round16(y * (65536 - d) + longint'(comb_lp[s]) * d, 16));
                    comb_lp[s] = lp[23:0];
                    v = clamp24(x + round16(lp * fb, 16));
                    comb_mem[cbase + p] = v[23:0];
                    comb_pos[s] = (p + 1 >= n) ? 0 : p + 1;
                    acc += y;
                    cbase += n;
                end
                w = clamp24(acc);
                for (int j = 0; j < N_AP; j++) begin
                    s = ch * N_AP + j;
                    n = taps(AP_TUNE[j], ch);
                    p = ap_pos[s];
                    if (p >= n) p = 0;
                    b = ap_mem[abase + p];
                    v = clamp24(w + round16(b, 1));
                    ap_mem[abase + p] = v[23:0];
                    ap_pos[s] = (p + 1 >= n) ? 0 : p + 1;
                    w = clamp24(b - w);
                    abase += n;
                end
                wet[ch] = w;
            end
            for (int ch = 0; ch < 2; ch++) begin
                v = wet[ch] * longint'(cfg.wet_same) + wet[1-ch] * longint'(cfg.wet_cross)
                  + smp[ch] * longint'(cfg.dry_gain);
                v = clamp24(round16(v, 16));
                if (ch == 0) exp_left.push_back(v[23:0]);
                else exp_right.push_back(v[23:0]);
            end
        endfunction

        function void check_result(logic signed [23:0] l, logic signed [23:0] r);
            logic signed [23:0] el, er;
            if (exp_left.size() == 0) begin
                $display("%0t: unexpected result expected none actual %0d %0d", $time, l, r);
                errors++;
                return;
            end
            el = exp_left.pop_front();
            er = exp_right.pop_front();
            checked++;
            if (l !== el) begin
                $display("%0t: left_result expected %0d actual %0d", $time, el, l);
                errors++;
            end
            if (r !== er) begin
                $display("%0t: right_result expected %0d actual %0d", $time, er, r);
                errors++;
            end
        endfunction
    endclass
endpackage

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top-level testbench for the stereo comb/allpass reverb core
module testbench;
    import scar_pkg::*;
    import scar_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   n_sent;
    int   n_cfg;

    scar_in_if  in_ch ();
    scar_out_if out_ch ();
    scar_cfg_if cfg_ch ();

    reverb_scoreboard sb;

    stereo_comb_allpass_reverb_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit: clearing pass plus ~1500 items at worst-case pacing
    initial begin
        #200ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // hold the item until accepted, then drop valid for one cycle
    task automatic send_pair(logic [23:0] l, logic [23:0] r);
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= l;
        in_ch.right_sample <= r;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(l, r);
        n_sent++;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [17:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        n_cfg++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until all results are back, then let the datapath settle
    task automatic drain();
        while (sb.exp_left.size() != 0) @(posedge i_clk);
        idle_cycles(200);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random(int n, bit paced);
        for (int i = 0; i < n; i++) begin
            send_pair(rand_sample(), rand_sample());
            if (paced) idle_cycles(gap_len());
        end
    endtask

    // random register setting, extremes included
    task automatic random_setting();
        write_reg(REG_INPUT_GAIN, ($urandom_range(0, 3) == 0) ? 18'd65536
                                  : 18'($urandom_range(0, 131071)));
        write_reg(REG_DAMPING, 18'($urandom_range(0, 131071)));
        write_reg(REG_FEEDBACK, ($urandom_range(0, 1) == 0) ? 18'd65536
                                : 18'($urandom_range(0, 131071)));
        write_reg(REG_DRY_GAIN, 18'($urandom));
        write_reg(REG_WET_SAME, 18'($urandom));
        write_reg(REG_WET_CROSS, 18'($urandom));
        write_reg(REG_FREEZE, 18'($urandom_range(0, 3) == 0));
    endtask

    // result sink with random stalls
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if ($urandom_range(0, 49) == 0) begin
                out_ch.ready <= 1'b0;
                idle_cycles($urandom_range(20, 250));
            end
            out_ch.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.left_result, out_ch.right_result);
        end
    end

    initial begin
        sb = new();
        n_sent = 0;
        n_cfg = 0;
        in_ch.valid = 1'b0;
        in_ch.left_sample = '0;
        in_ch.right_sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_INPUT_GAIN;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        idle_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset settings, then loud, frozen and muted settings
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000001, 24'hFFFFFF);
        send_pair(24'h555555, 24'hAAAAAA);
        drain();
        write_reg(REG_INPUT_GAIN, 18'd65536);
        write_reg(REG_DAMPING, 18'd131071);
        write_reg(REG_FEEDBACK, 18'd131071);
        write_reg(REG_DRY_GAIN, 18'd262143);
        write_reg(REG_WET_SAME, 18'd262143);
        write_reg(REG_WET_CROSS, 18'd262143);
        send_random(8, 1'b0);
        drain();
        write_reg(REG_FREEZE, 18'd1);
        write_reg(REG_DAMPING, 18'd0);
        send_random(6, 1'b0);
        drain();
        write_reg(REG_FREEZE, 18'd0);
        write_reg(REG_INPUT_GAIN, 18'd0);
        write_reg(REG_FEEDBACK, 18'd0);
        write_reg(REG_DRY_GAIN, 18'd0);
        write_reg(REG_WET_SAME, 18'd0);
        write_reg(REG_WET_CROSS, 18'd0);
        send_random(4, 1'b0);
        drain();

        // random phases, each under a fresh setting
        for (int ph = 0; ph < 12; ph++) begin
            random_setting();
            send_random(120, ph % 3 != 0);
            drain();
        end

        $display("Sent %0d sample pairs, checked %0d results, %0d register writes.",
                 n_sent, sb.checked, n_cfg);
        $display("Phases covered reset, saturating, frozen, muted and random settings.");
        if (sb.errors == 0 && sb.exp_left.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
